@@ rtl/isotp_pkg.sv @@
`default_nettype none
package isotp_pkg;

  // ISO-TP protocol control bytes
  localparam logic [7:0] PCI_FIRST_FRAME = 8'h10;
  localparam logic [3:0] PCI_CONSEC_HI   = 4'h2;

  // single and first frame length limits, in bytes after the control byte
  localparam logic [7:0] SF_LEN_MIN = 8'd2;
  localparam logic [7:0] SF_LEN_MAX = 8'd7;
  localparam logic [7:0] FF_LEN_MIN = 8'd2;

  // payload start within the frame, by frame type
  localparam logic [2:0] SF_START = 3'd3;
  localparam logic [2:0] FF_START = 3'd4;
  localparam logic [2:0] CF_START = 3'd1;

  // payload bytes carried by each frame type at most
  localparam logic [2:0] FF_MAX_BYTES = 3'd4;
  localparam logic [2:0] CF_MAX_BYTES = 3'd7;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
  localparam logic [1:0] STATUS_BAD_SEQ  = 2'd2;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

  // default depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // one classified frame, ready for the streaming back end
  typedef struct packed {
    logic [7:0]  service;
    logic [7:0]  pid;
    logic [63:0] frame;      // byte n at bits [8n+7:8n]
    logic [2:0]  start;      // frame byte of the first payload byte
    logic [2:0]  count;      // payload bytes to stream, 0 gives one empty result
    logic [7:0]  base_pos;   // payload index of the first streamed byte
    logic        finish;     // message completes or aborts with this frame
    logic [1:0]  status;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/isotp_front.sv @@
`default_nettype none
module isotp_front
  import isotp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       frame_valid,
  input  wire logic [7:0] frame_byte0,
  input  wire logic [7:0] frame_byte1,
  input  wire logic [7:0] frame_byte2,
  input  wire logic [7:0] frame_byte3,
  input  wire logic [7:0] frame_byte4,
  input  wire logic [7:0] frame_byte5,
  input  wire logic [7:0] frame_byte6,
  input  wire logic [7:0] frame_byte7,
  input  wire logic       queue_full,
  output logic            push,
  output job_t            push_job
);

  logic       in_progress, in_progress_next;
  logic [7:0] total_length, total_length_next;
  logic [7:0] position, position_next;
  logic [7:0] held_service, held_service_next;
  logic [7:0] held_pid, held_pid_next;
  logic [3:0] sequence_count, sequence_count_next;

  logic       accept;
  logic [7:0] remain;
  logic [7:0] ff_length;
  logic [7:0] sf_length;

  assign accept = frame_valid & ~queue_full;
  assign push   = accept;

  assign remain    = (total_length > position) ? (total_length - position) : 8'd0;
  assign ff_length = frame_byte1 - FF_LEN_MIN;
  assign sf_length = frame_byte0 - SF_LEN_MIN;

  // classify the frame and work out the next message state
  always_comb begin
    in_progress_next    = in_progress;
    total_length_next   = total_length;
    position_next       = position;
    held_service_next   = held_service;
    held_pid_next       = held_pid;
    sequence_count_next = sequence_count;

    push_job.frame    = {frame_byte7, frame_byte6, frame_byte5, frame_byte4,
                         frame_byte3, frame_byte2, frame_byte1, frame_byte0};
    push_job.service  = held_service;
    push_job.pid      = held_pid;
    push_job.start    = CF_START;
    push_job.count    = 3'd0;
    push_job.base_pos = 8'd0;
    push_job.finish   = 1'b1;
    push_job.status   = STATUS_OK;

    if (in_progress) begin
      if (frame_byte0 != {PCI_CONSEC_HI, sequence_count}) begin
        // abort on sequence mismatch
        in_progress_next = 1'b0;
        push_job.status  = STATUS_BAD_SEQ;
      end else begin
        push_job.start    = CF_START;
        push_job.base_pos = position;
        if (remain > {5'd0, CF_MAX_BYTES}) begin
          push_job.count = CF_MAX_BYTES;
          push_job.finish = 1'b0;
        end else begin
          push_job.count = remain[2:0];
          push_job.finish = 1'b1;
          in_progress_next = 1'b0;
        end
        sequence_count_next = sequence_count + 4'd1;
        position_next = position + {5'd0, push_job.count};
      end
    end else if (frame_byte0 == PCI_FIRST_FRAME) begin
      if (frame_byte1 < FF_LEN_MIN) begin
        push_job.status = STATUS_BAD_LEN;
      end else begin
        held_service_next = frame_byte2;
        held_pid_next     = frame_byte3;
        push_job.service  = frame_byte2;
        push_job.pid      = frame_byte3;
        total_length_next = ff_length;
        push_job.start    = FF_START;
        if (ff_length > {5'd0, FF_MAX_BYTES}) begin
          push_job.count      = FF_MAX_BYTES;
          push_job.finish     = 1'b0;
          in_progress_next    = 1'b1;
          sequence_count_next = 4'd1;
        end else begin
          push_job.count  = ff_length[2:0];
          push_job.finish = 1'b1;
        end
        position_next = {5'd0, push_job.count};
      end
    end else if (frame_byte0 < PCI_FIRST_FRAME) begin
      if (frame_byte0 < SF_LEN_MIN || frame_byte0 > SF_LEN_MAX) begin
        push_job.status = STATUS_BAD_LEN;
      end else begin
        held_service_next = frame_byte1;
        held_pid_next     = frame_byte2;
        push_job.service  = frame_byte1;
        push_job.pid      = frame_byte2;
        total_length_next = sf_length;
        push_job.start    = SF_START;
        push_job.count    = sf_length[2:0];
        position_next     = sf_length;
      end
    end else begin
      push_job.status = STATUS_BAD_TYPE;
    end
  end

  // commit message state on each accepted frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress    <= 1'b0;
      total_length   <= 8'd0;
      position       <= 8'd0;
      held_service   <= 8'd0;
      held_pid       <= 8'd0;
      sequence_count <= 4'd0;
    end else if (accept) begin
      in_progress    <= in_progress_next;
      total_length   <= total_length_next;
      position       <= position_next;
      held_service   <= held_service_next;
      held_pid       <= held_pid_next;
      sequence_count <= sequence_count_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/isotp_queue.sv @@
`default_nettype none
module isotp_queue
  import isotp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_FULL);
  assign empty    = (fill == '0);
  assign head_job = slots[rd_ptr];

  // store incoming jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/isotp_back.sv @@
`default_nettype none
module isotp_back
  import isotp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  queue_empty,
  input  job_t       head_job,
  output logic       pop,
  output logic       result_valid,
  input  wire logic  result_stall,
  output logic [7:0] service_byte,
  output logic [7:0] pid_byte,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic [7:0] byte_index,
  output logic       message_done,
  output logic [1:0] status,
  output logic       last_of_frame
);

  logic [2:0] step;
  logic       load;
  logic       last;
  logic       has_byte;
  logic [2:0] sel;
  logic [7:0] picked;

  assign load     = ~queue_empty & (~result_valid | ~result_stall);
  assign has_byte = (head_job.count != 3'd0);
  assign last     = has_byte ? (step == head_job.count - 3'd1) : 1'b1;
  assign pop      = load & last;
  assign sel      = head_job.start + step;
  assign picked   = head_job.frame[{sel, 3'b000} +: 8];

  // walk through the payload bytes of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
    end else if (load) begin
      step <= last ? 3'd0 : step + 3'd1;
    end
  end

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      service_byte  <= head_job.service;
      pid_byte      <= head_job.pid;
      data_byte     <= has_byte ? picked : 8'd0;
      byte_valid    <= has_byte;
      byte_index    <= has_byte ? head_job.base_pos + {5'd0, step} : 8'd0;
      message_done  <= head_job.finish & last;
      status        <= head_job.status;
      last_of_frame <= last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/isotp_obd_response_reassembler.sv @@
// Channel   Direction  Handshake                    Payload
// frame     in         frame_valid / frame_stall    frame_byte0 .. frame_byte7
// result    out        result_valid / result_stall  service_byte .. last_of_frame
//
// The front end takes one frame per cycle while the job queue has room.
// The back end sends one result per cycle while result_stall is low; a frame
// gives 1 to 7 results (one per payload byte, one when it carries none).
// A taken frame is written into a queue slot, and its first result then goes to the output register.
// Reset is synchronous; rst clears message state and the queue.
// A stalled result stays in the output register; the queue fills behind it.
`default_nettype none
module isotp_obd_response_reassembler
  import isotp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       frame_valid,
  output logic            frame_stall,
  input  wire logic [7:0] frame_byte0,
  input  wire logic [7:0] frame_byte1,
  input  wire logic [7:0] frame_byte2,
  input  wire logic [7:0] frame_byte3,
  input  wire logic [7:0] frame_byte4,
  input  wire logic [7:0] frame_byte5,
  input  wire logic [7:0] frame_byte6,
  input  wire logic [7:0] frame_byte7,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      service_byte,
  output logic [7:0]      pid_byte,
  output logic [7:0]      data_byte,
  output logic            byte_valid,
  output logic [7:0]      byte_index,
  output logic            message_done,
  output logic [1:0]      status,
  output logic            last_of_frame
);

  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  job_t push_job;
  job_t head_job;

  assign frame_stall = queue_full;

  isotp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_byte0 (frame_byte0),
    .frame_byte1 (frame_byte1),
    .frame_byte2 (frame_byte2),
    .frame_byte3 (frame_byte3),
    .frame_byte4 (frame_byte4),
    .frame_byte5 (frame_byte5),
    .frame_byte6 (frame_byte6),
    .frame_byte7 (frame_byte7),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  isotp_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head_job (head_job)
  );

  isotp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .head_job      (head_job),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .service_byte  (service_byte),
    .pid_byte      (pid_byte),
    .data_byte     (data_byte),
    .byte_valid    (byte_valid),
    .byte_index    (byte_index),
    .message_done  (message_done),
    .status        (status),
    .last_of_frame (last_of_frame)
  );

endmodule
`default_nettype wire

@@ rtl/isotp_checker.sv @@
`default_nettype none
module isotp_checker
  import isotp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       result_valid,
  input wire logic       result_stall,
  input wire logic [7:0] data_byte,
  input wire logic       byte_valid,
  input wire logic [7:0] byte_index,
  input wire logic       message_done,
  input wire logic [1:0] status,
  input wire logic       last_of_frame
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // empty results carry zero data and index
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_valid |-> data_byte == 8'd0 && byte_index == 8'd0)
    else $error("empty result carries data");

  // an error result ends the message and the frame, without a byte
  a_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_OK |-> !byte_valid && message_done && last_of_frame)
    else $error("error result malformed");

endmodule

bind isotp_obd_response_reassembler isotp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .data_byte     (data_byte),
  .byte_valid    (byte_valid),
  .byte_index    (byte_index),
  .message_done  (message_done),
  .status        (status),
  .last_of_frame (last_of_frame)
);
`default_nettype wire
